FILE: rtl/tsp_reduced_matrix_bound_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef TSP_REDUCED_MATRIX_BOUND_UNIT_ASSERT_SVH
`define TSP_REDUCED_MATRIX_BOUND_UNIT_ASSERT_SVH

`define TRMB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define TRMB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/trmb_pkg.sv
`default_nettype none
package trmb_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_ROOT   = 2'd2,
        FUNC_BRANCH = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic [15:0] entry_value;
        logic        entry_infinite;
        logic [31:0] base_cost;
    } req_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        read_infinite;
        logic [31:0] bound_cost;
        logic        overflow_flag;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_REMEMBER,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_SUB,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        CLR_NONE,
        CLR_ROOT,
        CLR_ROW,
        CLR_COL,
        CLR_BACK
    } clr_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_req;
        logic       mem_rd;
        logic       mem_wr_host;
        logic       remember;
        clr_t       clr;
        logic       scan_start;
        logic       scan_acc;
        logic       sub_wr;
        logic       add_min;
        logic       col_pass;
        logic       sum_clear;
        logic       rsp_read;
        logic       rsp_bound;
        logic       rsp_oor;
    } cmd_t;

    typedef struct packed {
        logic have_min;
    } stat_t;

    localparam logic [16:0] INF_ENTRY = 17'h10000;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

FILE: rtl/trmb_datapath.sv
`default_nettype none
module trmb_datapath #(
    parameter int CITIES = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire trmb_pkg::req_t req,
    input  wire trmb_pkg::cmd_t cmd,
    input  wire logic [$clog2(CITIES)-1:0] outer,
    input  wire logic [$clog2(CITIES)-1:0] inner,
    output trmb_pkg::stat_t     stat,
    output trmb_pkg::rsp_t      rsp
);
    localparam int IW = $clog2(CITIES);
    localparam int AW = 2 * IW;

    logic [16:0] mem [2**AW];
    logic [16:0] rd_reg;
    trmb_pkg::req_t req_reg;
    logic [IW-1:0] ri, ci;
    logic [16:0] rem_reg;
    logic [15:0] min_reg;
    logic        have_reg;
    logic [33:0] sum_reg;
    logic [AW-1:0] waddr, raddr;
    logic [16:0] wdata;
    logic        we;
    logic [IW-1:0] r_sel, c_sel;
    logic [33:0] total;

    assign ri = IW'(req_reg.row_index);
    assign ci = IW'(req_reg.col_index);

    // Pass cursor: row pass walks outer=row, inner=col; column pass swaps.
    assign r_sel = cmd.col_pass ? inner : outer;
    assign c_sel = cmd.col_pass ? outer : inner;

    always_comb begin
        raddr = {r_sel, c_sel};
        if (cmd.mem_rd || cmd.remember) begin
            raddr = {ri, ci};
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = {r_sel, c_sel};
        wdata = trmb_pkg::INF_ENTRY;
        if (cmd.mem_wr_host) begin
            we = 1'b1;
            waddr = {IW'(req.row_index), IW'(req.col_index)};
            wdata = req.entry_infinite ? trmb_pkg::INF_ENTRY : {1'b0, req.entry_value};
        end else begin
            case (cmd.clr)
                trmb_pkg::CLR_ROOT: begin we = 1'b1; waddr = '0; end
                trmb_pkg::CLR_ROW:  begin we = 1'b1; waddr = {ri, inner}; end
                trmb_pkg::CLR_COL:  begin we = 1'b1; waddr = {inner, ci}; end
                trmb_pkg::CLR_BACK: begin we = 1'b1; waddr = {ci, {IW{1'b0}}}; end
                default: ;
            endcase
            if (cmd.sub_wr && !rd_reg[16]) begin
                we = 1'b1;
                wdata = {1'b0, rd_reg[15:0] - min_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= req;
        end
        if (cmd.remember) begin
            rem_reg <= mem[{ri, ci}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            have_reg <= 1'b0;
        end else if (cmd.scan_acc && !rd_reg[16]) begin
            have_reg <= 1'b1;
        end
        if (cmd.scan_acc && !rd_reg[16] && (!have_reg || rd_reg[15:0] < min_reg)) begin
            min_reg <= rd_reg[15:0];
        end
    end

    assign stat.have_min = have_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sum_clear) begin
            sum_reg <= '0;
        end else if (cmd.add_min && have_reg) begin
            sum_reg <= sum_reg + {18'd0, min_reg};
        end
    end

    assign total = sum_reg + {2'd0, req_reg.base_cost} + {18'd0, rem_reg[15:0]};

    always_ff @(posedge aclk) begin
        if (cmd.rsp_read) begin
            rsp.read_value    <= rd_reg[16] ? 16'd0 : rd_reg[15:0];
            rsp.read_infinite <= rd_reg[16];
            rsp.bound_cost    <= '0;
            rsp.overflow_flag <= 1'b0;
        end else if (cmd.rsp_oor) begin
            rsp.read_value    <= '0;
            rsp.read_infinite <= (req_reg.func == trmb_pkg::FUNC_READ);
            rsp.bound_cost    <= (req_reg.func == trmb_pkg::FUNC_READ) ? 32'd0
                                                                       : req_reg.base_cost;
            rsp.overflow_flag <= (req_reg.func != trmb_pkg::FUNC_READ);
        end else if (cmd.rsp_bound) begin
            rsp.read_value    <= '0;
            rsp.read_infinite <= 1'b0;
            if (req_reg.func == trmb_pkg::FUNC_ROOT) begin
                rsp.bound_cost    <= (sum_reg[33:32] != 2'd0) ? trmb_pkg::SAT32 : sum_reg[31:0];
                rsp.overflow_flag <= (sum_reg[33:32] != 2'd0);
            end else if (rem_reg[16] || total[33:32] != 2'd0) begin
                rsp.bound_cost    <= trmb_pkg::SAT32;
                rsp.overflow_flag <= 1'b1;
            end else begin
                rsp.bound_cost    <= total[31:0];
                rsp.overflow_flag <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/trmb_ctrl.sv
`default_nettype none
module trmb_ctrl #(
    parameter int CITIES = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire trmb_pkg::req_t  s_req,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire trmb_pkg::stat_t stat,
    output trmb_pkg::cmd_t       cmd,
    output logic [$clog2(CITIES)-1:0] outer,
    output logic [$clog2(CITIES)-1:0] inner
);
    localparam int IW = $clog2(CITIES);
    localparam logic [IW-1:0] LAST = IW'(CITIES - 1);

    trmb_pkg::state_t state_reg, state_next;
    logic [IW-1:0] outer_reg, outer_next, inner_reg, inner_next;
    logic [1:0] clr_ph_reg, clr_ph_next;
    logic col_reg, col_next;
    logic branch_reg, branch_next;
    logic mv_reg, mv_next;
    logic in_range;

    assign in_range = ({2'b0, s_req.row_index} < 6'(CITIES))
                   && ({2'b0, s_req.col_index} < 6'(CITIES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= trmb_pkg::ST_IDLE;
            outer_reg  <= '0;
            inner_reg  <= '0;
            clr_ph_reg <= '0;
            col_reg    <= 1'b0;
            branch_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            outer_reg  <= outer_next;
            inner_reg  <= inner_next;
            clr_ph_reg <= clr_ph_next;
            col_reg    <= col_next;
            branch_reg <= branch_next;
            mv_reg     <= mv_next;
        end
    end

    assign outer = outer_reg;
    assign inner = inner_reg;
    assign m_valid = mv_reg;

    always_comb begin
        state_next  = state_reg;
        outer_next  = outer_reg;
        inner_next  = inner_reg;
        clr_ph_next = clr_ph_reg;
        col_next    = col_reg;
        branch_next = branch_reg;
        mv_next     = mv_reg;
        cmd         = '0;
        cmd.clr     = trmb_pkg::CLR_NONE;
        cmd.col_pass = col_reg;
        s_ready     = 1'b0;
        case (state_reg)
            trmb_pkg::ST_IDLE: begin
                s_ready = !mv_reg;
                if (s_valid && s_ready) begin
                    cmd.load_req = 1'b1;
                    case (trmb_pkg::func_t'(s_req.func))
                        trmb_pkg::FUNC_WRITE: cmd.mem_wr_host = in_range;
                        trmb_pkg::FUNC_READ: begin
                            state_next = trmb_pkg::ST_READ;
                        end
                        trmb_pkg::FUNC_ROOT: begin
                            cmd.sum_clear = 1'b1;
                            branch_next = 1'b0;
                            state_next = trmb_pkg::ST_REMEMBER;
                        end
                        default: begin
                            cmd.sum_clear = 1'b1;
                            branch_next = 1'b1;
                            state_next = trmb_pkg::ST_REMEMBER;
                        end
                    endcase
                    if (!in_range && s_req.func != trmb_pkg::FUNC_WRITE
                        && s_req.func != trmb_pkg::FUNC_ROOT) begin
                        state_next = trmb_pkg::ST_OUT;
                        clr_ph_next = 2'd3;
                    end else begin
                        clr_ph_next = 2'd0;
                    end
                end
            end
            trmb_pkg::ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = trmb_pkg::ST_FINISH;
                clr_ph_next = 2'd1;
            end
            trmb_pkg::ST_REMEMBER: begin
                cmd.remember = 1'b1;
                inner_next = '0;
                state_next = trmb_pkg::ST_CLEAR;
            end
            trmb_pkg::ST_CLEAR: begin
                if (!branch_reg) begin
                    cmd.clr = trmb_pkg::CLR_ROOT;
                    clr_ph_next = 2'd3;
                end else begin
                    case (clr_ph_reg)
                        2'd0: cmd.clr = trmb_pkg::CLR_ROW;
                        2'd1: cmd.clr = trmb_pkg::CLR_COL;
                        default: cmd.clr = trmb_pkg::CLR_BACK;
                    endcase
                    inner_next = inner_reg + 1'b1;
                    if (clr_ph_reg == 2'd2) begin
                        clr_ph_next = 2'd3;
                    end else if (inner_reg == LAST) begin
                        inner_next = '0;
                        clr_ph_next = clr_ph_reg + 2'd1;
                    end
                end
                if (clr_ph_next == 2'd3) begin
                    outer_next = '0;
                    inner_next = '0;
                    col_next = 1'b0;
                    state_next = trmb_pkg::ST_SCAN;
                end
            end
            trmb_pkg::ST_SCAN: begin
                // read address issued this cycle; data compared next cycle
                if (inner_reg == '0) begin
                    cmd.scan_start = 1'b1;
                end else begin
                    cmd.scan_acc = 1'b1;
                end
                inner_next = inner_reg + 1'b1;
                if (inner_reg == LAST) begin
                    state_next = trmb_pkg::ST_SCAN_LAST;
                end
            end
            trmb_pkg::ST_SCAN_LAST: begin
                cmd.scan_acc = 1'b1;
                inner_next = '0;
                state_next = trmb_pkg::ST_SUB;
            end
            trmb_pkg::ST_SUB: begin
                // issue read at inner, then write back the same element
                if (inner_reg == '0 && clr_ph_reg == 2'd3) begin
                    cmd.add_min = 1'b1;
                    clr_ph_next = 2'd0;
                    inner_next = '0;
                    if (!stat.have_min) begin
                        clr_ph_next = 2'd2;
                    end
                end else if (clr_ph_reg == 2'd0) begin
                    clr_ph_next = 2'd1;
                end else if (clr_ph_reg == 2'd1) begin
                    cmd.sub_wr = 1'b1;
                    if (inner_reg == LAST) begin
                        clr_ph_next = 2'd2;
                    end else begin
                        clr_ph_next = 2'd0;
                        inner_next = inner_reg + 1'b1;
                    end
                end
                if (clr_ph_reg == 2'd2) begin
                    clr_ph_next = 2'd3;
                    inner_next = '0;
                    outer_next = outer_reg + 1'b1;
                    state_next = trmb_pkg::ST_SCAN;
                    if (outer_reg == LAST) begin
                        outer_next = '0;
                        if (col_reg) begin
                            state_next = trmb_pkg::ST_FINISH;
                            clr_ph_next = 2'd0;
                        end else begin
                            col_next = 1'b1;
                        end
                    end
                end
            end
            trmb_pkg::ST_FINISH: begin
                if (clr_ph_reg == 2'd1) begin
                    cmd.rsp_read = 1'b1;
                end else begin
                    cmd.rsp_bound = 1'b1;
                end
                mv_next = 1'b1;
                state_next = trmb_pkg::ST_IDLE;
            end
            trmb_pkg::ST_OUT: begin
                cmd.rsp_oor = 1'b1;
                mv_next = 1'b1;
                state_next = trmb_pkg::ST_IDLE;
            end
            default: state_next = trmb_pkg::ST_IDLE;
        endcase
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/tsp_reduced_matrix_bound_unit.sv
// channel  | dir | handshake         | payload
// s_       | in  | s_valid/s_ready   | s_req  (trmb_pkg::req_t)
// m_       | out | m_valid/m_ready   | m_rsp  (trmb_pkg::rsp_t)
// A write gives no result; a read raises m_valid after passing through ST_READ and ST_FINISH.
// A root bound raises m_valid once each row, then each column, has been scanned and
// rewritten through the matrix memory; a line with no finite entry skips its rewrite.
// A branch first marks the row, column and return entry.
// s_ready is low while a request runs or a result waits on m_ready.
// aresetn is synchronous and active low; matrix contents are undefined until written.
`default_nettype none
module tsp_reduced_matrix_bound_unit #(
    parameter int CITIES = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire trmb_pkg::req_t s_req,
    output logic                m_valid,
    input  wire logic           m_ready,
    output trmb_pkg::rsp_t      m_rsp
);
    localparam int IW = $clog2(CITIES);

    trmb_pkg::cmd_t  cmd;
    trmb_pkg::stat_t stat;
    logic [IW-1:0] outer, inner;

    trmb_ctrl #(.CITIES(CITIES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd), .outer(outer), .inner(inner)
    );

    trmb_datapath #(.CITIES(CITIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .req(s_req), .cmd(cmd),
        .outer(outer), .inner(inner), .stat(stat), .rsp(m_rsp)
    );
endmodule
`default_nettype wire

FILE: rtl/trmb_checker.sv
`default_nettype none
`include "tsp_reduced_matrix_bound_unit_assert.svh"
module trmb_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire trmb_pkg::req_t s_req,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire trmb_pkg::rsp_t m_rsp
);
    `TRMB_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rsp))
    `TRMB_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_valid, !s_ready)
    `TRMB_ASSERT_NXT(a_write_silent, aclk, aresetn, s_valid && s_ready && s_req.func == trmb_pkg::FUNC_WRITE, !m_valid)
    `TRMB_ASSERT_IMP(a_read_clean, aclk, aresetn, m_valid && m_rsp.read_infinite, m_rsp.read_value == 16'd0)
endmodule

bind tsp_reduced_matrix_bound_unit trmb_checker u_trmb_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
    .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
);
`default_nettype wire
